### sv/dif_pkg.sv
`timescale 1ns / 1ps

package dif_pkg;

  // item commands
  localparam logic [1:0] CMD_SERVICE = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;

  // panel command bytes
  localparam logic [7:0] PNL_COL_ADDR  = 8'h2A;
  localparam logic [7:0] PNL_MEM_WRITE = 8'h2C;
  localparam logic [7:0] PNL_SLEEP_OUT = 8'h11;
  localparam logic [7:0] PNL_SETUP_A   = 8'h4C;
  localparam logic [7:0] PNL_SETUP_B   = 8'h4D;
  localparam logic [7:0] PNL_SETUP_C   = 8'h4E;
  localparam logic [7:0] BLANK_BYTE    = 8'hFF;

  // start-up timing in ms
  localparam logic [31:0] DL_RESET      = 32'd50;
  localparam logic [31:0] DL_AFTER_CLR  = 32'd10;
  localparam logic [31:0] DL_AFTER_A    = 32'd4;
  localparam logic [31:0] DL_AFTER_B    = 32'd1;
  localparam logic [31:0] DL_AFTER_C    = 32'd500;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam logic REG_SHOW_ON_BOOT = 1'b0;  // paddr[2]

  // queue sizes
  localparam int unsigned JOBQ_DEPTH = 4;
  localparam int unsigned JOBQ_PW    = $clog2(JOBQ_DEPTH);
  localparam int unsigned JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);
  localparam int unsigned OQ_DEPTH   = 4;
  localparam int unsigned OQ_PW      = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW      = $clog2(OQ_DEPTH + 1);

  typedef enum logic [6:0] {
    ST_RESET_WAIT  = 7'b0000001,
    ST_CLEAR       = 7'b0000010,
    ST_AFTER_CLEAR = 7'b0000100,
    ST_AFTER_A     = 7'b0001000,
    ST_AFTER_B     = 7'b0010000,
    ST_AFTER_C     = 7'b0100000,
    ST_READY       = 7'b1000000
  } stage_e;

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_ADDR  = 4'b0100,
    B_BODY  = 4'b1000
  } bstate_e;

  typedef enum logic [2:0] {
    BODY_NONE,
    BODY_FILL,
    BODY_READ,
    BODY_SCRIPT,
    BODY_WRITE
  } body_e;

  typedef enum logic [1:0] {
    SCR_SLEEP,
    SCR_SETUP_A,
    SCR_SETUP_B,
    SCR_SETUP_C
  } script_e;

  typedef struct packed {
    logic       dc;
    logic [7:0] data;
  } word_t;

  typedef struct packed {
    logic        has_addr;
    body_e       body;
    logic [15:0] addr;
    logic [5:0]  count;
    script_e     script;
    logic [7:0]  wdata;
    logic        shown;
  } job_t;

  typedef struct packed {
    logic       dc;
    logic [7:0] data;
    logic       use_mem;
    logic       last;
    logic       shown;
  } emit_t;

  typedef struct packed {
    logic       dc;
    logic [7:0] data;
    logic       shown;
    logic       last;
  } out_word_t;

  function automatic logic [5:0] script_len(script_e s);
    logic [5:0] n;
    case (s)
      SCR_SLEEP:   n = 6'd1;
      SCR_SETUP_A: n = 6'd5;
      SCR_SETUP_B: n = 6'd4;
      SCR_SETUP_C: n = 6'd2;
      default:     n = 6'd1;
    endcase
    return n;
  endfunction

  function automatic word_t script_word(script_e s, logic [5:0] k);
    word_t w;
    w = '{dc: 1'b1, data: 8'h00};
    case (s)
      SCR_SLEEP: begin
        w = '{dc: 1'b0, data: PNL_SLEEP_OUT};
      end
      SCR_SETUP_A: begin
        case (k)
          6'd0:    w = '{dc: 1'b0, data: PNL_SETUP_A};
          6'd1:    w = '{dc: 1'b1, data: 8'h0C};
          default: w = '{dc: 1'b1, data: 8'h00};
        endcase
      end
      SCR_SETUP_B: begin
        case (k)
          6'd0:    w = '{dc: 1'b0, data: PNL_SETUP_B};
          6'd1:    w = '{dc: 1'b1, data: 8'hFF};
          6'd2:    w = '{dc: 1'b1, data: 8'h00};
          default: w = '{dc: 1'b1, data: 8'h7F};
        endcase
      end
      SCR_SETUP_C: begin
        case (k)
          6'd0:    w = '{dc: 1'b0, data: PNL_SETUP_C};
          default: w = '{dc: 1'b1, data: 8'h60};
        endcase
      end
      default: w = '{dc: 1'b1, data: 8'h00};
    endcase
    return w;
  endfunction

endpackage

### sv/dif_if.sv
`timescale 1ns / 1ps

interface dif_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] now_ms;
  logic [11:0] byte_index;
  logic [7:0]  byte_value;

  modport source (output valid, cmd, now_ms, byte_index, byte_value, input ready);
  modport sink (input valid, cmd, now_ms, byte_index, byte_value, output ready);
endinterface

interface dif_out_if;
  logic       valid;
  logic       ready;
  logic       dc_bit;
  logic [7:0] word_byte;
  logic       shown_verified;
  logic       last;

  modport source (output valid, dc_bit, word_byte, shown_verified, last, input ready);
  modport sink (input valid, dc_bit, word_byte, shown_verified, last, output ready);
endinterface

### sv/dif_front.sv
`timescale 1ns / 1ps

module dif_front #(
  parameter int unsigned FRAME_BYTES = 4096,
  parameter int unsigned SLICE_WORDS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  dif_in_if.sink          req_i,
  input  logic            show_on_boot_i,
  input  logic            clear_busy_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output dif_pkg::job_t   q_job_o
);

  localparam int unsigned PW = $clog2(FRAME_BYTES + SLICE_WORDS);
  localparam logic [PW-1:0] FB = PW'(FRAME_BYTES);
  localparam logic [PW-1:0] SL = PW'(SLICE_WORDS);

  dif_pkg::stage_e stage_q, stage_d;
  logic [31:0]     deadline_q, deadline_d;
  logic [PW-1:0]   position_q, position_d;
  logic            sending_q, sending_d;
  logic            siv_q, siv_d;
  logic            flag_q, flag_d;

  logic            accept;
  logic [31:0]     diff;
  logic            reached;
  logic [PW-1:0]   rem;
  logic [PW-1:0]   slice_cnt;
  logic [PW-1:0]   clr_sum;
  logic [PW-1:0]   snd_sum;
  dif_pkg::job_t   job;
  logic            push;

  assign req_i.ready = !clear_busy_i && !q_full_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    stage_d    = stage_q;
    deadline_d = deadline_q;
    position_d = position_q;
    sending_d  = sending_q;
    siv_d      = siv_q;
    flag_d     = flag_q;
    job        = '0;
    push       = 1'b0;

    // wrap-safe: deadline passed when the difference is non-negative
    diff      = req_i.now_ms - deadline_q;
    reached   = !diff[31];
    rem       = FB - position_q;
    slice_cnt = (rem < SL) ? rem : SL;
    clr_sum   = position_q + SL;
    snd_sum   = position_q + slice_cnt;

    if (accept) begin
      case (req_i.cmd)
        dif_pkg::CMD_SERVICE: begin
          if (reached) begin
            case (stage_q)
              dif_pkg::ST_RESET_WAIT: begin
                push       = 1'b1;
                job.body   = dif_pkg::BODY_SCRIPT;
                job.script = dif_pkg::SCR_SLEEP;
                position_d = '0;
                stage_d    = dif_pkg::ST_CLEAR;
              end
              dif_pkg::ST_CLEAR: begin
                push         = 1'b1;
                job.has_addr = (position_q[7:0] == 8'd0);
                job.addr     = 16'(position_q);
                job.body     = dif_pkg::BODY_FILL;
                job.count    = 6'(SLICE_WORDS);
                position_d   = clr_sum;
                if (clr_sum >= FB) begin
                  stage_d    = dif_pkg::ST_AFTER_CLEAR;
                  deadline_d = req_i.now_ms + dif_pkg::DL_AFTER_CLR;
                end
              end
              dif_pkg::ST_AFTER_CLEAR: begin
                push       = 1'b1;
                job.body   = dif_pkg::BODY_SCRIPT;
                job.script = dif_pkg::SCR_SETUP_A;
                stage_d    = dif_pkg::ST_AFTER_A;
                deadline_d = req_i.now_ms + dif_pkg::DL_AFTER_A;
              end
              dif_pkg::ST_AFTER_A: begin
                push       = 1'b1;
                job.body   = dif_pkg::BODY_SCRIPT;
                job.script = dif_pkg::SCR_SETUP_B;
                stage_d    = dif_pkg::ST_AFTER_B;
                deadline_d = req_i.now_ms + dif_pkg::DL_AFTER_B;
              end
              dif_pkg::ST_AFTER_B: begin
                push       = 1'b1;
                job.body   = dif_pkg::BODY_SCRIPT;
                job.script = dif_pkg::SCR_SETUP_C;
                stage_d    = dif_pkg::ST_AFTER_C;
                deadline_d = req_i.now_ms + dif_pkg::DL_AFTER_C;
              end
              dif_pkg::ST_AFTER_C: begin
                stage_d = dif_pkg::ST_READY;
                // automatic unverified send of whatever the store holds
                if (show_on_boot_i) begin
                  push         = 1'b1;
                  job.has_addr = 1'b1;
                  job.body     = dif_pkg::BODY_NONE;
                  job.addr     = 16'd0;
                  sending_d    = 1'b1;
                  siv_d        = 1'b0;
                  position_d   = '0;
                end
              end
              dif_pkg::ST_READY: begin
                deadline_d = req_i.now_ms;
                if (sending_q) begin
                  push       = 1'b1;
                  job.body   = dif_pkg::BODY_READ;
                  job.addr   = 16'(position_q);
                  job.count  = 6'(slice_cnt);
                  position_d = snd_sum;
                  if (snd_sum >= FB) begin
                    sending_d = 1'b0;
                    if (siv_q) flag_d = 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        dif_pkg::CMD_WRITE: begin
          if (17'(req_i.byte_index) < 17'(FRAME_BYTES)) begin
            push      = 1'b1;
            job.body  = dif_pkg::BODY_WRITE;
            job.addr  = 16'(req_i.byte_index);
            job.wdata = req_i.byte_value;
          end
        end
        dif_pkg::CMD_START: begin
          if (stage_q == dif_pkg::ST_READY && !sending_q) begin
            flag_d       = 1'b0;
            sending_d    = 1'b1;
            siv_d        = 1'b1;
            position_d   = '0;
            push         = 1'b1;
            job.has_addr = 1'b1;
            job.body     = dif_pkg::BODY_NONE;
            job.addr     = 16'd0;
          end
        end
        default: ;
      endcase
    end
    job.shown = flag_d;
  end

  assign q_push_o = push;
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= dif_pkg::ST_RESET_WAIT;
      deadline_q <= dif_pkg::DL_RESET;
      position_q <= '0;
      sending_q  <= 1'b0;
      siv_q      <= 1'b0;
      flag_q     <= 1'b0;
    end else begin
      stage_q    <= stage_d;
      deadline_q <= deadline_d;
      position_q <= position_d;
      sending_q  <= sending_d;
      siv_q      <= siv_d;
      flag_q     <= flag_d;
    end
  end

endmodule

### sv/dif_jobq.sv
`timescale 1ns / 1ps

module dif_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dif_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output dif_pkg::job_t job_o,
  output logic          empty_o
);

  dif_pkg::job_t                  mem_q [dif_pkg::JOBQ_DEPTH];
  logic [dif_pkg::JOBQ_PW-1:0]    wptr_q, rptr_q;
  logic [dif_pkg::JOBQ_CW-1:0]    cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == dif_pkg::JOBQ_CW'(dif_pkg::JOBQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/dif_back.sv
`timescale 1ns / 1ps

module dif_back #(
  parameter int unsigned FRAME_BYTES = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  dif_pkg::job_t q_job_i,
  output logic          q_pop_o,
  output logic          clear_busy_o,
  dif_out_if.source     word_o
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CW = dif_pkg::OQ_CW + 1;

  dif_pkg::bstate_e state_q, state_d;
  dif_pkg::job_t    job_q, job_d;
  logic [5:0]       idx_q, idx_d;
  logic [AW-1:0]    clr_q, clr_d;

  // frame store
  logic [7:0]       store_q [FRAME_BYTES];
  logic [7:0]       rdata_q;
  logic             we, re;
  logic [AW-1:0]    wa, ra;
  logic [7:0]       wd;

  // word stage between issue and output queue
  dif_pkg::emit_t   emit;
  logic             issue;
  logic             space;
  logic             b_valid_q;
  dif_pkg::emit_t   b_q;

  // output queue
  dif_pkg::out_word_t          oq_q [dif_pkg::OQ_DEPTH];
  dif_pkg::out_word_t          oq_in;
  dif_pkg::out_word_t          oq_head;
  logic [dif_pkg::OQ_PW-1:0]   owp_q, orp_q;
  logic [dif_pkg::OQ_CW-1:0]   ocnt_q, ocnt_d;
  logic                        o_pop;
  dif_pkg::word_t              sw;

  // a word is issued only when the output queue can take it even if nothing drains
  assign space = (CW'(ocnt_q) + CW'(b_valid_q)) < CW'(dif_pkg::OQ_DEPTH);
  assign clear_busy_o = (state_q == dif_pkg::B_CLEAR);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    idx_d   = idx_q;
    clr_d   = clr_q;
    q_pop_o = 1'b0;
    we      = 1'b0;
    wa      = '0;
    wd      = dif_pkg::BLANK_BYTE;
    re      = 1'b0;
    ra      = AW'(job_q.addr + 16'(idx_q));
    issue   = 1'b0;
    emit    = '0;
    sw      = dif_pkg::script_word(job_q.script, idx_q);
    emit.shown = job_q.shown;

    case (state_q)
      dif_pkg::B_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(FRAME_BYTES - 1)) state_d = dif_pkg::B_IDLE;
      end
      dif_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          idx_d   = '0;
          state_d = q_job_i.has_addr ? dif_pkg::B_ADDR : dif_pkg::B_BODY;
        end
      end
      dif_pkg::B_ADDR: begin
        case (idx_q[1:0])
          2'd0: begin
            emit.dc   = 1'b0;
            emit.data = dif_pkg::PNL_COL_ADDR;
          end
          2'd1: begin
            emit.dc   = 1'b1;
            emit.data = job_q.addr[15:8];
          end
          2'd2: begin
            emit.dc   = 1'b1;
            emit.data = job_q.addr[7:0];
          end
          default: begin
            emit.dc   = 1'b0;
            emit.data = dif_pkg::PNL_MEM_WRITE;
          end
        endcase
        emit.last = (idx_q[1:0] == 2'd3) && (job_q.body == dif_pkg::BODY_NONE);
        if (space) begin
          issue = 1'b1;
          idx_d = idx_q + 6'd1;
          if (idx_q[1:0] == 2'd3) begin
            idx_d   = '0;
            state_d = (job_q.body == dif_pkg::BODY_NONE) ? dif_pkg::B_IDLE : dif_pkg::B_BODY;
          end
        end
      end
      dif_pkg::B_BODY: begin
        case (job_q.body)
          dif_pkg::BODY_WRITE: begin
            we      = 1'b1;
            wa      = AW'(job_q.addr);
            wd      = job_q.wdata;
            state_d = dif_pkg::B_IDLE;
          end
          dif_pkg::BODY_FILL: begin
            emit.dc   = 1'b1;
            emit.data = dif_pkg::BLANK_BYTE;
            emit.last = (idx_q == job_q.count - 6'd1);
          end
          dif_pkg::BODY_READ: begin
            emit.dc      = 1'b1;
            emit.use_mem = 1'b1;
            emit.last    = (idx_q == job_q.count - 6'd1);
          end
          dif_pkg::BODY_SCRIPT: begin
            emit.dc   = sw.dc;
            emit.data = sw.data;
            emit.last = (idx_q == dif_pkg::script_len(job_q.script) - 6'd1);
          end
          default: state_d = dif_pkg::B_IDLE;
        endcase
        if (space && (job_q.body == dif_pkg::BODY_FILL || job_q.body == dif_pkg::BODY_READ ||
                      job_q.body == dif_pkg::BODY_SCRIPT)) begin
          issue = 1'b1;
          re    = emit.use_mem;
          idx_d = idx_q + 6'd1;
          if (emit.last) state_d = dif_pkg::B_IDLE;
        end
      end
      default: state_d = dif_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) store_q[wa] <= wd;
    if (re) rdata_q <= store_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dif_pkg::B_CLEAR;
      idx_q     <= '0;
      clr_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      clr_q     <= clr_d;
      b_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (issue) b_q <= emit;
  end

  // store data shows up in the cycle after the read is issued
  always_comb begin
    oq_in.dc    = b_q.dc;
    oq_in.data  = b_q.use_mem ? rdata_q : b_q.data;
    oq_in.shown = b_q.shown;
    oq_in.last  = b_q.last;
  end

  assign oq_head = oq_q[orp_q];
  assign o_pop   = word_o.valid && word_o.ready;

  assign word_o.valid          = (ocnt_q != '0);
  assign word_o.dc_bit         = oq_head.dc;
  assign word_o.word_byte      = oq_head.data;
  assign word_o.shown_verified = oq_head.shown;
  assign word_o.last           = oq_head.last;

  always_comb begin
    ocnt_d = ocnt_q;
    if (b_valid_q && !o_pop) ocnt_d = ocnt_q + 1'b1;
    else if (o_pop && !b_valid_q) ocnt_d = ocnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) oq_q[owp_q] <= oq_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (b_valid_q) owp_q <= owp_q + 1'b1;
      if (o_pop) orp_q <= orp_q + 1'b1;
      ocnt_q <= ocnt_d;
    end
  end

endmodule

### sv/display_init_and_frame_sender_core.sv
`timescale 1ns / 1ps

// channel  | dir | handshake       | payload
// ---------+-----+-----------------+---------------------------------------------
// req_i    | in  | valid / ready   | cmd, now_ms, byte_index, byte_value
// word_o   | out | valid / ready   | dc_bit, word_byte, shown_verified, last
// apb      | in  | psel / penable  | paddr, pwrite, pwdata, prdata (show_on_boot)
//
// the front takes one item per cycle while the job queue has room and no sweep runs;
// each item yields at most one job. the back runs a job at one word per cycle while the
// output queue has space, taking each job up when idle; a clear slice may lead with a
// four-word address header. after reset the back sweeps the store to 0xFF with ready low.
// a stalled word_o fills a four-word output queue, then the back and the job queue stall.

module display_init_and_frame_sender_core #(
  parameter int unsigned FRAME_BYTES = 4096,
  parameter int unsigned SLICE_WORDS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dif_in_if.sink                     req_i,
  dif_out_if.source                  word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dif_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic          show_on_boot_q;
  logic          clear_busy;
  logic          q_push, q_pop, q_full, q_empty;
  dif_pkg::job_t q_wjob, q_rjob;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dif_pkg::REG_SHOW_ON_BOOT) ? {31'd0, show_on_boot_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_on_boot_q <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == dif_pkg::REG_SHOW_ON_BOOT) begin
      show_on_boot_q <= pwdata[0];
    end
  end

  dif_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .SLICE_WORDS (SLICE_WORDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .show_on_boot_i (show_on_boot_q),
    .clear_busy_i   (clear_busy),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (q_wjob)
  );

  dif_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_wjob),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_rjob),
    .empty_o (q_empty)
  );

  dif_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_job_i      (q_rjob),
    .q_pop_o      (q_pop),
    .clear_busy_o (clear_busy),
    .word_o       (word_o)
  );

endmodule

### sv/dif_checker.sv
`timescale 1ns / 1ps

module dif_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       psel_i,
  input logic                       penable_i,
  input logic                       pwrite_i,
  input logic [dif_pkg::APB_AW-1:0] paddr_i,
  input logic [31:0]                pwdata_i,
  input logic [31:0]                prdata_i
);

  // a pending word is never withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // the store sweep keeps the input closed right after reset
  a_sweep_closed: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_i)
    else $error("input open during store sweep");

  // register readback follows the last write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && !paddr_i[2]
    |=> (paddr_i[2] || prdata_i[0] == $past(pwdata_i[0])))
    else $error("show_on_boot readback mismatch");

  a_cfg_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata_i[31:1] == 31'd0)
    else $error("unused register bits read nonzero");

endmodule

bind display_init_and_frame_sender_core dif_checker u_dif_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (word_o.valid),
  .out_ready_i (word_o.ready),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);
